FILE: hw/rtl/ofmvn_pkg.sv
// ofmvn_pkg: shared constants and codes for the online feature mean/variance normalizer
// no dependencies; used by the core, its checker and the testbench
`timescale 1ns / 1ps

package ofmvn_pkg;

  // sizing of the per-coefficient stores and the statistics window
  localparam int MAX_COEFS  = 64;
  localparam int MAX_WINDOW = 4096;
  localparam int IDX_W      = $clog2(MAX_COEFS);

  // field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 13;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int OUT_TDATA_W = 24;

  // statistics formats
  localparam int SUM_W   = 28;
  localparam int SUMSQ_W = 43;
  localparam int STAT_W  = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW    = 2'd0,
    REG_LOOKAHEAD = 2'd1,
    REG_COEFS     = 2'd2
  } cfg_reg_t;

  // kind of an input word
  typedef enum logic {
    KIND_INIT = 1'b0,
    KIND_DATA = 1'b1
  } kind_t;

endpackage

FILE: hw/rtl/ofmvn_ram.sv
// ofmvn_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module ofmvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/online_feature_mean_var_normalizer_core.sv
// An init word before the first data word reads the init sums and, within the lookahead frames,
// rewrites them; a data word runs the statistics update (three 32-step serial passes plus a
// 42-step serial divide), or only the divide while held. The first data word also builds the
// starting statistics for every one of the 64 coefficient slots before its own update. One word
// is in work at a time. Reset (rst_n low, synchronous) clears control and counters and presets
// the settings; the running statistics stores need no clearing, and the init sums are masked by
// per-slot valid bits. Depends on ofmvn_pkg and ofmvn_ram.
`timescale 1ns / 1ps

module online_feature_mean_var_normalizer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ofmvn_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample_value
  input  logic                                 in_tuser,   // [0] kind
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ofmvn_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] norm_value, [21:16] coef_index, [23:22] zero
  output logic                                 out_tuser,  // [0] divide_fault
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ofmvn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ofmvn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ofmvn_pkg::*;

  localparam int DIV_W     = 75;
  localparam int LEN_RECIP = 32;
  localparam int LEN_MEAN  = 44;
  localparam int LEN_EX2   = 75;
  localparam int LEN_OUT   = 42;

  typedef enum logic [4:0] {
    S_IDLE, S_IRD, S_IWR,
    S_FSTART, S_FRECIP, S_FRD, S_FRDW, S_FMEAN, S_FEX2, S_FSQ, S_FWR,
    S_DRD, S_DRDW, S_DMUL1, S_DMUL2, S_DSQ, S_DWR, S_DOUT, S_DDIV, S_DFIN
  } state_t;

  state_t state_r;

  // settings
  logic [FRAME_W-1:0] win_len_r, look_r;
  logic [CNT_W-1:0]   coefs_r;

  // control and working registers
  logic signed [SAMPLE_W-1:0] sx_r;
  logic [IDX_W-1:0]           idx_r, coef_cnt_r;
  logic [FRAME_W-1:0]         n_r, dfc_r, ifc_r;
  logic                       nzero_r, stats_ready_r, neg_r, ge_r, fault_r;
  logic [STAT_W-1:0]          recip_r, std_r;
  logic signed [STAT_W-1:0]   mean_r;
  logic [63:0]                s2_r;
  logic [SUMSQ_W-1:0]         sumsq_r;
  logic [MAX_COEFS-1:0]       init_vld_r;
  logic [SAMPLE_W-1:0]        y_r;
  logic                       out_valid_r, out_fault_r;
  logic [SAMPLE_W-1:0]        out_norm_r;
  logic [IDX_W-1:0]           out_idx_r;

  // serial units
  logic [DIV_W-1:0] div_a_r, div_ld_a;
  logic [31:0]      div_rem_r, div_b_r, div_ld_b;
  logic [6:0]       div_cnt_r, div_ld_len;
  logic             div_go;
  logic [32:0]      div_t, div_sub;
  logic             div_ge;

  logic [63:0] mul_a_r, mul_ld_a, mul_res;
  logic [31:0] mul_b_r;
  logic [95:0] mul_acc_r, mul_rnd;
  logic [5:0]  mul_cnt_r;
  logic        mul_go;

  logic [63:0] sq_v_r, sq_res_r, sq_bit_r, sq_ld, sq_sum;
  logic [5:0]  sq_cnt_r;
  logic        sq_go;
  logic        busy;

  // memories
  logic                       init_rd_en, init_wr_en, stat_rd_en, stat_wr_en;
  logic [SUMSQ_W+SUM_W-1:0]   init_wdata, init_rdata;
  logic [2*STAT_W-1:0]        stat_wdata, stat_rdata;

  // derived settings and indexes
  logic [FRAME_W-1:0] w_eff, l_eff, got, n_calc;
  logic [CNT_W-1:0]   cc_eff, idx_inc;
  logic [IDX_W-1:0]   idx_calc;
  logic               idx_wrap, hold, in_acc;

  // datapath values
  logic signed [31:0]         x24, sx32, rd_mean;
  logic [31:0]                sxsq, am, rd_std;
  logic signed [SUM_W-1:0]    rd_sum, new_sum;
  logic [SUMSQ_W-1:0]         rd_sumsq, new_sumsq;
  logic [SUM_W-1:0]           fm_mag;
  logic signed [45:0]         fmean46, m46;
  logic signed [32:0]         d33, num33;
  logic [32:0]                dm, nmag;
  logic [63:0]                ex2, f_var, x2, diff, var2;
  logic                       x2_ge;
  logic [LEN_MEAN-1:0]        mean_div;
  logic [LEN_OUT-1:0]         out_div;
  logic [LEN_OUT-1:0]         q_out;

  function automatic logic signed [31:0] sat_mean(input logic signed [45:0] v);
    if (v > 46'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -46'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // effective settings
  always_comb begin
    if (win_len_r == '0) begin
      w_eff = FRAME_W'(1);
    end else if (win_len_r > FRAME_W'(MAX_WINDOW)) begin
      w_eff = FRAME_W'(MAX_WINDOW);
    end else begin
      w_eff = win_len_r;
    end
    l_eff = (look_r > w_eff) ? w_eff : look_r;
    if (coefs_r == '0) begin
      cc_eff = CNT_W'(1);
    end else if (coefs_r > CNT_W'(MAX_COEFS)) begin
      cc_eff = CNT_W'(MAX_COEFS);
    end else begin
      cc_eff = coefs_r;
    end
  end

  assign got      = (ifc_r > l_eff) ? l_eff : ifc_r;
  assign n_calc   = (w_eff - l_eff) + got;
  assign idx_calc = ({1'b0, coef_cnt_r} >= cc_eff) ? '0 : coef_cnt_r;
  assign idx_inc  = {1'b0, idx_r} + CNT_W'(1);
  assign idx_wrap = idx_inc >= cc_eff;
  assign hold     = ({1'b0, dfc_r} + (FRAME_W+1)'(1)) < {1'b0, l_eff};
  assign in_acc   = ifc_r < l_eff;

  // init sample accumulation
  assign x24       = {sx_r, 16'b0};
  assign sx32      = 32'(sx_r);
  assign sxsq      = sx32 * sx32;
  assign rd_sum    = init_vld_r[idx_r] ? init_rdata[SUM_W-1:0] : '0;
  assign rd_sumsq  = init_vld_r[idx_r] ? init_rdata[SUMSQ_W+SUM_W-1:SUM_W] : '0;
  assign new_sum   = rd_sum + SUM_W'(sx_r);
  assign new_sumsq = rd_sumsq + SUMSQ_W'(sxsq);

  // starting statistics
  assign fm_mag   = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
  assign mean_div = {fm_mag, 16'b0} + LEN_MEAN'(n_r >> 1);
  assign fmean46  = neg_r ? -signed'({2'b0, div_a_r[LEN_MEAN-1:0]})
                          : signed'({2'b0, div_a_r[LEN_MEAN-1:0]});
  assign am       = mean_r[31] ? 32'(-mean_r) : 32'(mean_r);
  assign ex2      = div_a_r[63:0];
  assign f_var    = (ex2 > s2_r) ? ex2 - s2_r : 64'd0;

  // running update
  assign rd_mean = stat_rdata[STAT_W-1:0];
  assign rd_std  = stat_rdata[2*STAT_W-1:STAT_W];
  assign d33     = 33'(x24) - 33'(rd_mean);
  assign dm      = d33[32] ? 33'(-d33) : 33'(d33);
  assign m46     = neg_r ? 46'(mean_r) - signed'({1'b0, mul_res[44:0]})
                         : 46'(mean_r) + signed'({1'b0, mul_res[44:0]});
  assign x2      = {sxsq, 32'b0};
  assign x2_ge   = x2 >= s2_r;
  assign diff    = x2_ge ? x2 - s2_r : s2_r - x2;
  always_comb begin
    if (ge_r) begin
      var2 = s2_r + mul_res;
    end else if (mul_res > s2_r) begin
      var2 = 64'd0;
    end else begin
      var2 = s2_r - mul_res;
    end
  end

  // output division
  assign num33   = 33'(x24) - 33'(mean_r);
  assign nmag    = num33[32] ? 33'(-num33) : 33'(num33);
  assign out_div = LEN_OUT'({nmag, 8'b0}) + LEN_OUT'(std_r >> 1);
  assign q_out   = div_a_r[LEN_OUT-1:0];

  assign busy = (div_cnt_r != '0) || (mul_cnt_r != '0) || (sq_cnt_r != '0);

  // unit launches and memory strobes
  always_comb begin
    div_go     = 1'b0;
    div_ld_a   = '0;
    div_ld_b   = '0;
    div_ld_len = '0;
    mul_go     = 1'b0;
    mul_ld_a   = '0;
    sq_go      = 1'b0;
    sq_ld      = '0;
    init_rd_en = 1'b0;
    init_wr_en = 1'b0;
    stat_rd_en = 1'b0;
    stat_wr_en = 1'b0;
    case (state_r)
      S_IRD: begin
        init_rd_en = 1'b1;
      end
      S_IWR: begin
        init_wr_en = in_acc;
      end
      S_FSTART: begin
        if (n_calc != '0) begin
          div_go     = 1'b1;
          div_ld_a   = {32'h8000_0000 + 32'(n_calc >> 1), (DIV_W-LEN_RECIP)'(0)};
          div_ld_b   = 32'(n_calc);
          div_ld_len = 7'(LEN_RECIP);
        end
      end
      S_FRD: begin
        init_rd_en = 1'b1;
      end
      S_FRDW: begin
        if (!nzero_r) begin
          div_go     = 1'b1;
          div_ld_a   = {mean_div, (DIV_W-LEN_MEAN)'(0)};
          div_ld_b   = 32'(n_r);
          div_ld_len = 7'(LEN_MEAN);
        end
      end
      S_FMEAN: begin
        if (!busy) begin
          div_go     = 1'b1;
          div_ld_a   = {sumsq_r, 32'b0};
          div_ld_b   = 32'(n_r);
          div_ld_len = 7'(LEN_EX2);
        end
      end
      S_FEX2: begin
        if (!busy) begin
          sq_go = 1'b1;
          sq_ld = f_var;
        end
      end
      S_FWR: begin
        stat_wr_en = 1'b1;
      end
      S_DRD: begin
        stat_rd_en = 1'b1;
      end
      S_DRDW: begin
        if (!hold) begin
          mul_go   = 1'b1;
          mul_ld_a = 64'(dm);
        end
      end
      S_DMUL1: begin
        if (!busy) begin
          mul_go   = 1'b1;
          mul_ld_a = diff;
        end
      end
      S_DMUL2: begin
        if (!busy) begin
          sq_go = 1'b1;
          sq_ld = var2;
        end
      end
      S_DWR: begin
        stat_wr_en = 1'b1;
      end
      S_DOUT: begin
        if (std_r != '0) begin
          div_go     = 1'b1;
          div_ld_a   = {out_div, (DIV_W-LEN_OUT)'(0)};
          div_ld_b   = std_r;
          div_ld_len = 7'(LEN_OUT);
        end
      end
      default: begin
      end
    endcase
  end

  assign init_wdata = {new_sumsq, new_sum};
  assign stat_wdata = {std_r, mean_r};

  // sequencer: state, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      stats_ready_r <= 1'b0;
      coef_cnt_r    <= '0;
      dfc_r         <= '0;
      ifc_r         <= '0;
      init_vld_r    <= '0;
      recip_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DFIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sx_r  <= in_tdata;
            idx_r <= idx_calc;
            if (in_tuser == KIND_DATA) begin
              state_r <= stats_ready_r ? S_DRD : S_FSTART;
            end else if (!stats_ready_r) begin
              state_r <= S_IRD;
            end
          end
        end
        S_IRD: begin
          state_r <= S_IWR;
        end
        S_IWR: begin
          if (in_acc) begin
            init_vld_r[idx_r] <= 1'b1;
          end
          if (idx_wrap) begin
            coef_cnt_r <= '0;
            if (in_acc) begin
              ifc_r <= ifc_r + FRAME_W'(1);
            end
          end else begin
            coef_cnt_r <= idx_inc[IDX_W-1:0];
          end
          state_r <= S_IDLE;
        end
        S_FSTART: begin
          n_r     <= n_calc;
          nzero_r <= (n_calc == '0);
          idx_r   <= '0;
          if (n_calc == '0) begin
            recip_r <= 32'h8000_0000;
            state_r <= S_FRD;
          end else begin
            state_r <= S_FRECIP;
          end
        end
        S_FRECIP: begin
          if (!busy) begin
            recip_r <= div_a_r[31:0];
            state_r <= S_FRD;
          end
        end
        S_FRD: begin
          state_r <= S_FRDW;
        end
        S_FRDW: begin
          neg_r   <= rd_sum[SUM_W-1];
          sumsq_r <= rd_sumsq;
          if (nzero_r) begin
            mean_r  <= '0;
            std_r   <= '0;
            state_r <= S_FWR;
          end else begin
            state_r <= S_FMEAN;
          end
        end
        S_FMEAN: begin
          if (!busy) begin
            mean_r  <= sat_mean(fmean46);
            state_r <= S_FEX2;
          end
        end
        S_FEX2: begin
          s2_r <= am * am;
          if (!busy) begin
            state_r <= S_FSQ;
          end
        end
        S_FSQ: begin
          if (!busy) begin
            std_r   <= sq_res_r[31:0];
            state_r <= S_FWR;
          end
        end
        S_FWR: begin
          if (idx_r == IDX_W'(MAX_COEFS-1)) begin
            stats_ready_r <= 1'b1;
            coef_cnt_r    <= '0;
            dfc_r         <= '0;
            ifc_r         <= '0;
            init_vld_r    <= '0;
            idx_r         <= '0;
            state_r       <= S_DRD;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_FRD;
          end
        end
        S_DRD: begin
          state_r <= S_DRDW;
        end
        S_DRDW: begin
          mean_r  <= rd_mean;
          std_r   <= rd_std;
          neg_r   <= d33[32];
          state_r <= hold ? S_DOUT : S_DMUL1;
        end
        S_DMUL1: begin
          s2_r <= std_r * std_r;
          if (!busy) begin
            mean_r  <= sat_mean(m46);
            ge_r    <= x2_ge;
            state_r <= S_DMUL2;
          end
        end
        S_DMUL2: begin
          if (!busy) begin
            state_r <= S_DSQ;
          end
        end
        S_DSQ: begin
          if (!busy) begin
            std_r   <= sq_res_r[31:0];
            state_r <= S_DWR;
          end
        end
        S_DWR: begin
          state_r <= S_DOUT;
        end
        S_DOUT: begin
          neg_r <= num33[32];
          if (std_r == '0) begin
            fault_r <= 1'b1;
            if (num33 == '0) begin
              y_r <= 16'h0000;
            end else begin
              y_r <= num33[32] ? 16'h8000 : 16'h7FFF;
            end
            state_r <= S_DFIN;
          end else begin
            fault_r <= 1'b0;
            state_r <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (!busy) begin
            if (neg_r) begin
              y_r <= (q_out > LEN_OUT'(32768)) ? 16'h8000 : 16'(-q_out[15:0]);
            end else begin
              y_r <= (q_out > LEN_OUT'(32767)) ? 16'h7FFF : q_out[15:0];
            end
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_norm_r  <= y_r;
            out_idx_r   <= idx_r;
            out_fault_r <= fault_r;
            if (idx_wrap) begin
              coef_cnt_r <= '0;
              if (dfc_r != '1) begin
                dfc_r <= dfc_r + FRAME_W'(1);
              end
            end else begin
              coef_cnt_r <= idx_inc[IDX_W-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= FRAME_W'(300);
      look_r    <= '0;
      coefs_r   <= CNT_W'(39);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW:    win_len_r <= cfg_data;
        REG_LOOKAHEAD: look_r    <= cfg_data;
        REG_COEFS:     coefs_r   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_t   = {div_rem_r, div_a_r[DIV_W-1]};
  assign div_ge  = div_t >= {1'b0, div_b_r};
  assign div_sub = div_t - {1'b0, div_b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_go) begin
      div_a_r   <= div_ld_a;
      div_b_r   <= div_ld_b;
      div_rem_r <= '0;
      div_cnt_r <= div_ld_len;
    end else if (div_cnt_r != '0) begin
      div_rem_r <= div_ge ? div_sub[31:0] : div_t[31:0];
      div_a_r   <= {div_a_r[DIV_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 7'd1;
    end
  end

  // shift-add multiplier by the window reciprocal, one bit per cycle
  assign mul_rnd = mul_acc_r + 96'h4000_0000;
  assign mul_res = mul_rnd[94:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (mul_go) begin
      mul_a_r   <= mul_ld_a;
      mul_b_r   <= recip_r;
      mul_acc_r <= '0;
      mul_cnt_r <= 6'd32;
    end else if (mul_cnt_r != '0) begin
      mul_acc_r <= {mul_acc_r[94:0], 1'b0} + (mul_b_r[31] ? {32'b0, mul_a_r} : 96'd0);
      mul_b_r   <= {mul_b_r[30:0], 1'b0};
      mul_cnt_r <= mul_cnt_r - 6'd1;
    end
  end

  // integer square root, one result bit per cycle
  assign sq_sum = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_go) begin
      sq_v_r   <= sq_ld;
      sq_res_r <= '0;
      sq_bit_r <= 64'h4000_0000_0000_0000;
      sq_cnt_r <= 6'd32;
    end else if (sq_cnt_r != '0) begin
      if (sq_v_r >= sq_sum) begin
        sq_v_r   <= sq_v_r - sq_sum;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
      sq_cnt_r <= sq_cnt_r - 6'd1;
    end
  end

  // init sums, valid bits mark written slots
  ofmvn_ram #(
    .WIDTH (SUMSQ_W + SUM_W),
    .DEPTH (MAX_COEFS)
  ) u_init_ram (
    .clk     (clk),
    .wr_en   (init_wr_en),
    .wr_addr (idx_r),
    .wr_data (init_wdata),
    .rd_en   (init_rd_en),
    .rd_addr (idx_r),
    .rd_data (init_rdata)
  );

  // running mean and deviation, every slot written before first read
  ofmvn_ram #(
    .WIDTH (2 * STAT_W),
    .DEPTH (MAX_COEFS)
  ) u_stat_ram (
    .clk     (clk),
    .wr_en   (stat_wr_en),
    .wr_addr (idx_r),
    .wr_data (stat_wdata),
    .rd_en   (stat_rd_en),
    .rd_addr (idx_r),
    .rd_data (stat_rdata)
  );

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_idx_r, out_norm_r};
  assign out_tuser  = out_fault_r;

endmodule

FILE: hw/rtl/ofmvn_checker.sv
// ofmvn_checker: port-level checks on the normalizer core, bound into every core instance
// depends on ofmvn_pkg and online_feature_mean_var_normalizer_core
`timescale 1ns / 1ps

module ofmvn_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [ofmvn_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                 out_tuser
);
  import ofmvn_pkg::*;

  // a faulted word carries only a saturated or zero value
  a_fault_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[15:0] == 16'h7FFF || out_tdata[15:0] == 16'h8000
       || out_tdata[15:0] == 16'h0000))
    else $error("fault word with unsaturated value");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a data word always keeps the block busy in the cycle after it is accepted
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_DATA) |=> !in_tready)
    else $error("data word accepted without work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind online_feature_mean_var_normalizer_core ofmvn_checker u_ofmvn_checker (.*);

FILE: verif/testbench.sv
// testbench: self-checking bench for online_feature_mean_var_normalizer_core
// checks every result word against a bit-exact predictor of the normalizer's statistics
// depends on ofmvn_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
  import ofmvn_pkg::*;

  // clock, reset and block ports
  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata;   // [15:0] sample_value
  logic                   in_tuser;   // [0] kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] norm_value, [21:16] coef_index, [23:22] zero
  logic                   out_tuser;  // [0] divide_fault
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  online_feature_mean_var_normalizer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  localparam int DRAIN_CYCLES = 200;
  localparam int FRAME_SAT    = 8191;

  typedef struct packed {
    logic [15:0] norm;
    logic [5:0]  idx;
    logic        fault;
  } norm_result_t;

  norm_result_t expected_q[$];

  // predictor state
  logic [12:0]        window_reg, look_reg;
  logic [6:0]         coefs_reg;
  logic signed [31:0] mean_tab[MAX_COEFS];
  logic [31:0]        dev_tab[MAX_COEFS];
  longint             sum_tab[MAX_COEFS];
  longint unsigned    sumsq_tab[MAX_COEFS];
  int                 coef_pos, data_frames, init_frames;
  bit                 stats_ready;
  logic [31:0]        recip;

  // run bookkeeping
  int gap_pct, stall_pct;
  int fail_count, checked_count, fault_count, data_sent, noise_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // effective register values
  function automatic int eff_window();
    int w;
    w = window_reg;
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return w;
  endfunction

  function automatic int eff_look();
    return (look_reg > eff_window()) ? eff_window() : int'(look_reg);
  endfunction

  function automatic int eff_coefs();
    int c;
    c = coefs_reg;
    if (c == 0) c = 1;
    if (c > MAX_COEFS) c = MAX_COEFS;
    return c;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // rounded d * r / 2^31
  function automatic longint unsigned scale_by_recip(longint unsigned d, logic [31:0] r);
    longint unsigned hi, lo, rr;
    hi = d >> 31;
    lo = d & 64'h7FFF_FFFF;
    rr = r;
    return hi * rr + ((lo * rr + (64'd1 << 30)) >> 31);
  endfunction

  function automatic logic signed [31:0] clamp_q24(longint m);
    if (m > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (m < -64'sd2147483648) return 32'sh8000_0000;
    return m[31:0];
  endfunction

  // starting mean and deviation over the init window
  task automatic build_start_stats();
    longint unsigned n, mag, m, q, r, ex2, am, msq;
    longint mean;
    int l, got;
    l = eff_look();
    got = (init_frames > l) ? l : init_frames;
    n = longint'(eff_window() - l + got);
    recip = (n == 0) ? 32'h8000_0000 : 32'((64'h8000_0000 + n / 2) / n);
    for (int c = 0; c < MAX_COEFS; c++) begin
      if (n == 0) begin
        mean_tab[c] = 0;
        dev_tab[c] = 0;
      end else begin
        mag = (sum_tab[c] < 0) ? longint'(-sum_tab[c]) : longint'(sum_tab[c]);
        m = ((mag << 16) + n / 2) / n;
        mean = (sum_tab[c] < 0) ? -longint'(m) : longint'(m);
        mean_tab[c] = clamp_q24(mean);
        q = sumsq_tab[c] / n;
        r = sumsq_tab[c] % n;
        ex2 = (q << 32) + ((r << 32) / n);
        am = (mean_tab[c] < 0) ? longint'(-longint'(mean_tab[c])) : longint'(mean_tab[c]);
        msq = am * am;
        dev_tab[c] = 32'(int_sqrt((ex2 > msq) ? ex2 - msq : 0));
      end
    end
  endtask

  // advance the predictor by one accepted word
  task automatic predict_word(kind_t kind, logic [15:0] raw);
    longint sx, x24, d, num;
    longint unsigned dm, delta, s2, x2, var_q, dv, mag, qv, sd;
    int cc, idx;
    norm_result_t res;
    cc = eff_coefs();
    sx = longint'($signed(raw));
    if (kind == KIND_INIT) begin
      if (stats_ready) return;
      idx = (coef_pos >= cc) ? 0 : coef_pos;
      if (init_frames < eff_look()) begin
        sum_tab[idx] += sx;
        sumsq_tab[idx] += longint'(sx * sx);
      end
      coef_pos = idx + 1;
      if (coef_pos >= cc) begin
        coef_pos = 0;
        if (init_frames < eff_look()) init_frames++;
      end
      return;
    end
    if (!stats_ready) begin
      build_start_stats();
      stats_ready = 1'b1;
      coef_pos = 0;
      data_frames = 0;
      init_frames = 0;
      for (int c = 0; c < MAX_COEFS; c++) begin
        sum_tab[c] = 0;
        sumsq_tab[c] = 0;
      end
    end
    idx = (coef_pos >= cc) ? 0 : coef_pos;
    x24 = sx * 65536;
    // forgetting update unless inside the lookahead frames
    if (!(data_frames + 1 < eff_look())) begin
      d = x24 - longint'(mean_tab[idx]);
      dm = (d < 0) ? longint'(-d) : longint'(d);
      delta = scale_by_recip(dm, recip);
      s2 = longint'(dev_tab[idx]) * longint'(dev_tab[idx]);
      x2 = longint'(sx * sx) << 32;
      mean_tab[idx] = clamp_q24((d < 0) ? longint'(mean_tab[idx]) - longint'(delta)
                                        : longint'(mean_tab[idx]) + longint'(delta));
      if (x2 >= s2) begin
        var_q = s2 + scale_by_recip(x2 - s2, recip);
      end else begin
        dv = scale_by_recip(s2 - x2, recip);
        var_q = (dv > s2) ? 0 : s2 - dv;
      end
      dev_tab[idx] = 32'(int_sqrt(var_q));
    end
    num = x24 - longint'(mean_tab[idx]);
    sd = dev_tab[idx];
    res.idx = 6'(idx);
    res.fault = 1'b0;
    if (sd == 0) begin
      res.fault = 1'b1;
      res.norm = (num > 0) ? 16'h7FFF : ((num < 0) ? 16'h8000 : 16'h0000);
    end else begin
      mag = (num < 0) ? longint'(-num) : longint'(num);
      qv = ((mag << 8) + sd / 2) / sd;
      if (num < 0) res.norm = (qv > 32768) ? 16'h8000 : 16'(-longint'(qv));
      else res.norm = (qv > 32767) ? 16'h7FFF : 16'(qv);
    end
    expected_q.push_back(res);
    coef_pos = idx + 1;
    if (coef_pos >= cc) begin
      coef_pos = 0;
      if (data_frames < FRAME_SAT) data_frames++;
    end
  endtask

  // result receiver with random stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    norm_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word: norm_value %h coef_index %0d", out_tdata[15:0],
               out_tdata[21:16]);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        checked_count++;
        if (exp_res.fault) fault_count++;
        if (out_tdata[15:0] !== exp_res.norm) begin
          $error("norm_value: expected %h actual %h", exp_res.norm, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[21:16] !== exp_res.idx) begin
          $error("coef_index: expected %0d actual %0d", exp_res.idx, out_tdata[21:16]);
          fail_count++;
        end
        if (out_tuser !== exp_res.fault) begin
          $error("divide_fault: expected %b actual %b", exp_res.fault, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // send one word, with a random gap ahead of it
  task automatic send_word(kind_t kind, logic [15:0] value);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    predict_word(kind, value);
    if (kind == KIND_DATA) data_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW:    window_reg = value;
      REG_LOOKAHEAD: look_reg = value;
      REG_COEFS:     coefs_reg = value[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(1)) return 16'($urandom_range(65535));
    return 16'(int'($urandom_range(4000)) - 2000);
  endfunction

  task automatic test_reset();
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    out_tready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    window_reg = 13'd300;
    look_reg = 13'd0;
    coefs_reg = 7'd39;
    for (int c = 0; c < MAX_COEFS; c++) begin
      mean_tab[c] = 0;
      dev_tab[c] = 0;
      sum_tab[c] = 0;
      sumsq_tab[c] = 0;
    end
    coef_pos = 0;
    data_frames = 0;
    init_frames = 0;
    stats_ready = 1'b0;
    recip = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // init frames: coefficient 0 all zero, coefficient 1 at the extremes;
  // one frame beyond the lookahead and a partial frame follow
  task automatic test_init_window();
    write_reg(REG_WINDOW, 13'd6);
    write_reg(REG_LOOKAHEAD, 13'd4);
    write_reg(REG_COEFS, 7'd2);
    for (int f = 0; f < 5; f++) begin
      send_word(KIND_INIT, 16'h0000);
      send_word(KIND_INIT, f[0] ? 16'h8000 : 16'h7FFF);
    end
    send_word(KIND_INIT, 16'h1234);
  endtask

  // held frames with zero deviation on coefficient 0, then a late init word
  // and updates at the sample extremes
  task automatic test_zero_dev_and_updates();
    send_word(KIND_DATA, 16'h0100);
    send_word(KIND_DATA, 16'h7FFF);
    send_word(KIND_DATA, 16'hFF00);
    send_word(KIND_DATA, 16'h8000);
    send_word(KIND_DATA, 16'h0000);
    send_word(KIND_DATA, 16'h0001);
    send_word(KIND_INIT, 16'h5555);
    send_word(KIND_DATA, 16'h7FFF);
    send_word(KIND_DATA, 16'h8000);
    send_word(KIND_DATA, 16'hFFFF);
    send_word(KIND_DATA, 16'h0000);
    wait_drained();
  endtask

  // random phases with new settings and idling modes
  task automatic test_random_phases();
    logic [12:0] win, look;
    logic [6:0]  nc;
    int phase, target;
    phase = 0;
    while (data_sent < 860) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      case (phase)
        0: begin win = 13'd0;    look = 13'd0;    nc = 7'd64;  end
        1: begin win = 13'd8191; look = 13'd8191; nc = 7'd0;  end
        2: begin win = 13'd4096; look = 13'd4096; nc = 7'd127; end
        3: begin win = 13'd1;    look = 13'd0;    nc = 7'd1;   end
        default: begin
          win = 13'($urandom_range(8191));
          look = $urandom_range(3) == 0 ? 13'($urandom_range(8191))
                                        : 13'($urandom_range(12));
          nc = $urandom_range(4) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(1, 8));
        end
      endcase
      write_reg(REG_WINDOW, win);
      write_reg(REG_LOOKAHEAD, look);
      write_reg(REG_COEFS, nc);
      target = data_sent + ((phase == 0) ? 140 : $urandom_range(30, 70));
      while (data_sent < target) begin
        if ($urandom_range(99) < 6) begin
          send_word(KIND_INIT, rand_sample());
          noise_sent++;
        end else begin
          send_word(KIND_DATA, rand_sample());
        end
        // one pause until everything is back, in the middle of a phase
        if (phase == 5 && data_sent == target - 15) begin
          in_tvalid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
      phase++;
    end
  endtask

  initial begin
    fail_count = 0;
    checked_count = 0;
    fault_count = 0;
    data_sent = 0;
    noise_sent = 0;
    test_reset();
    wait_drained();
    test_init_window();
    test_zero_dev_and_updates();
    test_random_phases();
    $display("covered %0d data words and %0d ignored init words over extreme and random settings",
             data_sent, noise_sent);
    $display("checked %0d result words, %0d with zero deviation", checked_count, fault_count);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ofmvn_pkg.sv
hw/rtl/ofmvn_ram.sv
hw/rtl/online_feature_mean_var_normalizer_core.sv
hw/rtl/ofmvn_checker.sv
verif/testbench.sv
